// File: rtl/core/tls_pkg.sv
// ----------------------------------------------------------------------------
// Thread lifecycle scheduler package
// Shared types, codes and controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package tls_pkg;

	localparam int unsigned THREAD_SLOTS = 16;
	localparam int unsigned SW = $clog2(THREAD_SLOTS);
	localparam int unsigned CW = $clog2(THREAD_SLOTS + 1);

	typedef logic [SW-1:0] slot_t;
	typedef logic [CW-1:0] cnt_t;

	typedef enum logic [2:0] {
		ST_FREE    = 3'd0,
		ST_READY   = 3'd1,
		ST_RUNNING = 3'd2,
		ST_BLOCKED = 3'd3,
		ST_ZOMBIE  = 3'd4,
		ST_DEAD    = 3'd5
	} tstate_t;

	typedef enum logic [2:0] {
		K_CREATE   = 3'd0,
		K_REGISTER = 3'd1,
		K_YIELD    = 3'd2,
		K_EXIT     = 3'd3,
		K_JOIN     = 3'd4,
		K_RESUME   = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		S_OK       = 3'd0,
		S_INVALID  = 3'd1,
		S_NOFREE   = 3'd2,
		S_FINISHED = 3'd3,
		S_DEADLOCK = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		OP_NONE    = 4'd0,
		OP_DECODE  = 4'd1,
		OP_SCAN    = 4'd2,
		OP_EXITHD  = 4'd3,
		OP_WAKE    = 4'd4,
		OP_Y_FREE  = 4'd5,
		OP_Y_REQ   = 4'd6,
		OP_Y_DISP  = 4'd7
	} op_t;

	typedef struct packed {
		op_t  op;
		slot_t idx;
	} cmd_t;

	typedef struct packed {
		logic    do_yield;
		logic    scan_hit;
		logic    wake_last;
		logic    wake_pend;
	} stat_t;

endpackage

// File: rtl/core/tls_datapath.sv
// ----------------------------------------------------------------------------
// Thread lifecycle scheduler datapath
// Slot table, list pointers and per-command updates, one slot per cycle for walks.
// ----------------------------------------------------------------------------
module tls_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_take,
	input  logic [2:0]        kind,
	input  logic [3:0]        target_thread,
	input  tls_pkg::cmd_t     cmd,
	output tls_pkg::stat_t    stat,
	output logic [2:0]        res_status,
	output logic [3:0]        res_new,
	output logic [3:0]        res_running,
	output logic              res_switched
);

	tls_pkg::tstate_t st_q [tls_pkg::THREAD_SLOTS];
	logic [tls_pkg::THREAD_SLOTS-1:0] jp_q;
	tls_pkg::slot_t link_q [tls_pkg::THREAD_SLOTS];
	tls_pkg::slot_t jh_q [tls_pkg::THREAD_SLOTS];
	tls_pkg::slot_t jt_q [tls_pkg::THREAD_SLOTS];
	tls_pkg::slot_t rh_q, rt_q, dh_q, cur_q, wx_q, wt_q;
	logic rp_q, dp_q, halted_q;
	logic [2:0] kind_q;
	logic [3:0] tgt_q;
	logic [2:0] status_q;
	tls_pkg::slot_t new_q;
	logic sw_q, yield_q, wk_q;

	logic t_ok, t_alloc;
	tls_pkg::slot_t t_sl, hsel;

	assign t_ok = 32'(tgt_q) < tls_pkg::THREAD_SLOTS;
	assign t_sl = tls_pkg::SW'(tgt_q);
	assign t_alloc = t_ok && st_q[t_sl] != tls_pkg::ST_FREE;
	assign hsel = rh_q;

	assign stat.do_yield = yield_q;
	assign stat.scan_hit = !halted_q && st_q[cmd.idx] == tls_pkg::ST_FREE;
	assign stat.wake_last = wx_q == wt_q;
	assign stat.wake_pend = wk_q;

	assign res_status = status_q;
	assign res_new = 4'(new_q);
	assign res_running = 4'(cur_q);
	assign res_switched = sw_q;

	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_q <= kind;
			tgt_q <= target_thread;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tls_pkg::THREAD_SLOTS; i++) begin
				st_q[i] <= (i == 0) ? tls_pkg::ST_RUNNING : tls_pkg::ST_FREE;
			end
			jp_q <= '0;
			rh_q <= '0;
			rt_q <= '0;
			rp_q <= 1'b0;
			dh_q <= '0;
			dp_q <= 1'b0;
			cur_q <= '0;
			halted_q <= 1'b0;
			status_q <= 3'(tls_pkg::S_OK);
			new_q <= '0;
			sw_q <= 1'b0;
			yield_q <= 1'b0;
			wk_q <= 1'b0;
			wx_q <= '0;
			wt_q <= '0;
		end else begin
			unique case (cmd.op)
				tls_pkg::OP_DECODE: begin
					status_q <= 3'(tls_pkg::S_OK);
					new_q <= '0;
					sw_q <= 1'b0;
					yield_q <= 1'b0;
					wk_q <= 1'b0;
					if (halted_q) begin
						status_q <= (st_q[cur_q] == tls_pkg::ST_DEAD) ?
							3'(tls_pkg::S_FINISHED) : 3'(tls_pkg::S_DEADLOCK);
					end else begin
						case (kind_q)
							tls_pkg::K_CREATE: status_q <= 3'(tls_pkg::S_NOFREE);
							tls_pkg::K_REGISTER, tls_pkg::K_RESUME: begin
								if (!t_alloc) begin
									status_q <= 3'(tls_pkg::S_INVALID);
								end else begin
									if (kind_q == tls_pkg::K_RESUME) begin
										st_q[t_sl] <= tls_pkg::ST_READY;
									end
									if (rp_q) begin
										link_q[rt_q] <= t_sl;
									end else begin
										rh_q <= t_sl;
										rp_q <= 1'b1;
									end
									rt_q <= t_sl;
								end
							end
							tls_pkg::K_YIELD: yield_q <= 1'b1;
							tls_pkg::K_EXIT: begin
								yield_q <= 1'b1;
								if (jp_q[cur_q]) begin
									st_q[cur_q] <= tls_pkg::ST_DEAD;
									dh_q <= cur_q;
									dp_q <= 1'b1;
									wk_q <= 1'b1;
									wx_q <= jh_q[cur_q];
									wt_q <= jt_q[cur_q];
									jp_q[cur_q] <= 1'b0;
								end else begin
									st_q[cur_q] <= tls_pkg::ST_ZOMBIE;
								end
							end
							tls_pkg::K_JOIN: begin
								if (!t_alloc || t_sl == cur_q) begin
									status_q <= 3'(tls_pkg::S_INVALID);
								end else if (st_q[t_sl] == tls_pkg::ST_ZOMBIE) begin
									st_q[t_sl] <= tls_pkg::ST_DEAD;
									dh_q <= t_sl;
									dp_q <= 1'b1;
								end else begin
									yield_q <= 1'b1;
									st_q[cur_q] <= tls_pkg::ST_BLOCKED;
									if (jp_q[t_sl]) begin
										link_q[jt_q[t_sl]] <= cur_q;
									end else begin
										jh_q[t_sl] <= cur_q;
										jp_q[t_sl] <= 1'b1;
									end
									jt_q[t_sl] <= cur_q;
								end
							end
							default: status_q <= 3'(tls_pkg::S_INVALID);
						endcase
					end
				end
				tls_pkg::OP_SCAN: begin
					st_q[cmd.idx] <= tls_pkg::ST_READY;
					jp_q[cmd.idx] <= 1'b0;
					if (rp_q) begin
						link_q[rt_q] <= cmd.idx;
					end else begin
						rh_q <= cmd.idx;
						rp_q <= 1'b1;
					end
					rt_q <= cmd.idx;
					new_q <= cmd.idx;
					status_q <= 3'(tls_pkg::S_OK);
				end
				tls_pkg::OP_WAKE: begin
					st_q[wx_q] <= tls_pkg::ST_READY;
					if (rp_q) begin
						link_q[rt_q] <= wx_q;
					end else begin
						rh_q <= wx_q;
						rp_q <= 1'b1;
					end
					rt_q <= wx_q;
					wx_q <= link_q[wx_q];
				end
				tls_pkg::OP_Y_FREE: begin
					if (st_q[cmd.idx] == tls_pkg::ST_DEAD && cmd.idx != cur_q) begin
						st_q[cmd.idx] <= tls_pkg::ST_FREE;
					end
				end
				tls_pkg::OP_Y_REQ: begin
					if (st_q[cur_q] == tls_pkg::ST_DEAD) begin
						dh_q <= cur_q;
						dp_q <= 1'b1;
					end else begin
						dp_q <= 1'b0;
					end
					if (st_q[cur_q] == tls_pkg::ST_RUNNING) begin
						st_q[cur_q] <= tls_pkg::ST_READY;
						if (rp_q) begin
							link_q[rt_q] <= cur_q;
						end else begin
							rh_q <= cur_q;
							rp_q <= 1'b1;
						end
						rt_q <= cur_q;
					end
				end
				tls_pkg::OP_Y_DISP: begin
					if (!rp_q) begin
						halted_q <= 1'b1;
						status_q <= (st_q[cur_q] == tls_pkg::ST_DEAD) ?
							3'(tls_pkg::S_FINISHED) : 3'(tls_pkg::S_DEADLOCK);
					end else begin
						if (hsel == rt_q) begin
							rp_q <= 1'b0;
						end else begin
							rh_q <= link_q[hsel];
						end
						cur_q <= hsel;
						st_q[hsel] <= tls_pkg::ST_RUNNING;
						sw_q <= 1'b1;
						status_q <= 3'(tls_pkg::S_OK);
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/core/tls_ctrl.sv
// ----------------------------------------------------------------------------
// Thread lifecycle scheduler controller
// Sequences decode, slot scans, joiner walk and the yield steps.
// ----------------------------------------------------------------------------
module tls_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  logic [2:0]        kind,
	output logic              in_take,
	output tls_pkg::cmd_t     cmd,
	input  tls_pkg::stat_t    stat
);

	typedef enum logic [7:0] {
		C_IDLE   = 8'b00000001,
		C_DEC    = 8'b00000010,
		C_SCAN   = 8'b00000100,
		C_WAKE   = 8'b00001000,
		C_YFREE  = 8'b00010000,
		C_YREQ   = 8'b00100000,
		C_YDISP  = 8'b01000000,
		C_OUT    = 8'b10000000
	} cstate_t;

	cstate_t state_q;
	tls_pkg::slot_t idx_q;
	tls_pkg::cnt_t cnt_q;
	logic [2:0] kind_q;
	logic wake_q;

	localparam tls_pkg::slot_t LAST = tls_pkg::SW'(tls_pkg::THREAD_SLOTS - 1);

	assign in_ready = state_q == C_IDLE;
	assign in_take = in_valid && in_ready;
	assign out_valid = state_q == C_OUT;

	always_comb begin
		cmd.idx = idx_q;
		unique case (state_q)
			C_DEC: cmd.op = tls_pkg::OP_DECODE;
			C_SCAN: cmd.op = stat.scan_hit ? tls_pkg::OP_SCAN : tls_pkg::OP_NONE;
			C_WAKE: cmd.op = (wake_q && stat.wake_pend) ? tls_pkg::OP_WAKE :
				tls_pkg::OP_NONE;
			C_YFREE: cmd.op = tls_pkg::OP_Y_FREE;
			C_YREQ: cmd.op = tls_pkg::OP_Y_REQ;
			C_YDISP: cmd.op = tls_pkg::OP_Y_DISP;
			default: cmd.op = tls_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			idx_q <= '0;
			cnt_q <= '0;
			kind_q <= '0;
			wake_q <= 1'b0;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					if (in_take) begin
						kind_q <= kind;
						state_q <= C_DEC;
					end
				end
				C_DEC: begin
					idx_q <= '0;
					cnt_q <= '0;
					wake_q <= 1'b1;
					if (kind_q == tls_pkg::K_CREATE) begin
						state_q <= C_SCAN;
					end else begin
						state_q <= C_WAKE;
					end
				end
				C_SCAN: begin
					if (stat.scan_hit || idx_q == LAST) begin
						state_q <= C_OUT;
					end
					idx_q <= idx_q + 1'b1;
				end
				C_WAKE: begin
					// Walk only when decode of an exit found joiners.
					cnt_q <= cnt_q + 1'b1;
					if (stat.wake_last || 32'(cnt_q) == tls_pkg::THREAD_SLOTS - 1) begin
						wake_q <= 1'b0;
					end
					if (!stat.do_yield) begin
						state_q <= C_OUT;
					end else if (!wake_q || !stat.wake_pend ||
							kind_q != tls_pkg::K_EXIT ||
							stat.wake_last ||
							32'(cnt_q) == tls_pkg::THREAD_SLOTS - 1) begin
						state_q <= C_YFREE;
						idx_q <= '0;
					end
				end
				C_YFREE: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST) begin
						state_q <= C_YREQ;
					end
				end
				C_YREQ: state_q <= C_YDISP;
				C_YDISP: state_q <= C_OUT;
				C_OUT: begin
					if (out_ready) begin
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/thread_lifecycle_scheduler.sv
// Create scans slots one a cycle, exit walks joiners one a cycle, and
// yield sweeps all slots.
// Throughput: one command at a time; the next beat is taken after the result beat.
// Reset: slot 0 running, all others free, lists empty, not halted.
// ----------------------------------------------------------------------------
// Thread lifecycle scheduler top level
// Joins the sequencing controller to the slot table datapath.
// ----------------------------------------------------------------------------
module thread_lifecycle_scheduler (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] kind,
	input  logic [3:0] target_thread,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] status,
	output logic [3:0] new_thread,
	output logic [3:0] running_thread,
	output logic       switched
);

	tls_pkg::cmd_t cmd;
	tls_pkg::stat_t stat;
	logic in_take;

	tls_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .kind(kind),
		.in_take(in_take), .cmd(cmd), .stat(stat)
	);

	tls_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_take(in_take), .kind(kind),
		.target_thread(target_thread), .cmd(cmd), .stat(stat),
		.res_status(status), .res_new(new_thread), .res_running(running_thread),
		.res_switched(switched)
	);

endmodule

// File: rtl/core/tls_checker.sv
// ----------------------------------------------------------------------------
// Thread lifecycle scheduler checker
// Port-level properties of the result channel and status coding.
// ----------------------------------------------------------------------------
module tls_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] status,
	input logic       switched
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while result pending");
	a_sw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && switched |-> status == 3'd0)
		else $error("switch with error status");
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= 3'd4)
		else $error("bad status code");

endmodule

bind thread_lifecycle_scheduler tls_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .status(status),
	.switched(switched)
);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Thread lifecycle scheduler testbench
// Drives scheduler commands with bursty valid and a stalling result side,
// predicts each result from a local copy of the slot table and lists, and
// compares every result beat in order across all fields.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] tgt;
	} cmd_beat_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] new_thread;
		logic [3:0] running_thread;
		logic       switched;
	} sched_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] kind = '0;
	logic [3:0] target_thread = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic [3:0] new_thread;
	logic [3:0] running_thread;
	logic switched;

	thread_lifecycle_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .target_thread(target_thread),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .new_thread(new_thread),
		.running_thread(running_thread), .switched(switched)
	);

	always #5 clk = ~clk;

	cmd_beat_t pending_cmds[$];
	sched_res_t expected_results[$];
	int mismatches = 0;
	int cycles = 0;
	bit hold_off = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	int accepted = 0;

	// Shadow scheduler state.
	tls_pkg::tstate_t ss[16];
	logic [3:0] lnk[16], jhd[16], jtl[16];
	logic jpr[16];
	logic [3:0] rhd, rtl, cur;
	logic rpr, halted;

	task automatic sched_reset();
		for (int i = 0; i < 16; i++) begin
			ss[i] = tls_pkg::ST_FREE;
			lnk[i] = '0;
			jhd[i] = '0;
			jtl[i] = '0;
			jpr[i] = 1'b0;
		end
		ss[0] = tls_pkg::ST_RUNNING;
		rhd = '0;
		rtl = '0;
		cur = '0;
		rpr = 1'b0;
		halted = 1'b0;
	endtask

	task automatic ready_enqueue(input logic [3:0] x);
		if (rpr) begin
			lnk[rtl] = x;
			rtl = x;
		end else begin
			rhd = x;
			rtl = x;
			rpr = 1'b1;
		end
	endtask

	function automatic logic [2:0] halt_code();
		return (ss[cur] == tls_pkg::ST_DEAD) ? tls_pkg::S_FINISHED : tls_pkg::S_DEADLOCK;
	endfunction

	task automatic dispatch_next(output logic [2:0] st, inout logic sw);
		logic [3:0] nx;
		for (int i = 0; i < 16; i++)
			if (ss[i] == tls_pkg::ST_DEAD && i != cur) ss[i] = tls_pkg::ST_FREE;
		if (ss[cur] == tls_pkg::ST_RUNNING) begin
			ss[cur] = tls_pkg::ST_READY;
			ready_enqueue(cur);
		end
		if (!rpr) begin
			halted = 1'b1;
			st = halt_code();
		end else begin
			nx = rhd;
			if (nx == rtl) rpr = 1'b0;
			else rhd = lnk[nx];
			cur = nx;
			ss[nx] = tls_pkg::ST_RUNNING;
			sw = 1'b1;
			st = tls_pkg::S_OK;
		end
	endtask

	function automatic bit is_alloc(input logic [3:0] t);
		return ss[t] != tls_pkg::ST_FREE;
	endfunction

	task automatic schedule_cmd(input cmd_beat_t c);
		sched_res_t r;
		logic [2:0] st;
		logic sw;
		logic [3:0] x, nx;
		st = tls_pkg::S_OK;
		sw = 1'b0;
		r.new_thread = '0;
		if (halted) begin
			st = halt_code();
		end else begin
			case (c.kind)
				tls_pkg::K_CREATE: begin
					st = tls_pkg::S_NOFREE;
					for (int i = 0; i < 16; i++) begin
						if (st == tls_pkg::S_NOFREE && ss[i] == tls_pkg::ST_FREE) begin
							ss[i] = tls_pkg::ST_READY;
							jpr[i] = 1'b0;
							ready_enqueue(4'(i));
							r.new_thread = 4'(i);
							st = tls_pkg::S_OK;
						end
					end
				end
				tls_pkg::K_REGISTER, tls_pkg::K_RESUME: begin
					if (!is_alloc(c.tgt)) st = tls_pkg::S_INVALID;
					else begin
						if (c.kind == tls_pkg::K_RESUME) ss[c.tgt] = tls_pkg::ST_READY;
						ready_enqueue(c.tgt);
					end
				end
				tls_pkg::K_YIELD: dispatch_next(st, sw);
				tls_pkg::K_EXIT: begin
					if (jpr[cur]) begin
						x = jhd[cur];
						ss[cur] = tls_pkg::ST_DEAD;
						for (int i = 0; i < 16; i++) begin
							nx = lnk[x];
							ss[x] = tls_pkg::ST_READY;
							ready_enqueue(x);
							if (x == jtl[cur]) break;
							x = nx;
						end
						jpr[cur] = 1'b0;
					end else begin
						ss[cur] = tls_pkg::ST_ZOMBIE;
					end
					dispatch_next(st, sw);
				end
				tls_pkg::K_JOIN: begin
					if (!is_alloc(c.tgt) || c.tgt == cur) st = tls_pkg::S_INVALID;
					else if (ss[c.tgt] == tls_pkg::ST_ZOMBIE) ss[c.tgt] = tls_pkg::ST_DEAD;
					else begin
						ss[cur] = tls_pkg::ST_BLOCKED;
						if (jpr[c.tgt]) begin
							lnk[jtl[c.tgt]] = cur;
							jtl[c.tgt] = cur;
						end else begin
							jhd[c.tgt] = cur;
							jtl[c.tgt] = cur;
							jpr[c.tgt] = 1'b1;
						end
						dispatch_next(st, sw);
					end
				end
				default: st = tls_pkg::S_INVALID;
			endcase
		end
		r.status = st;
		r.running_thread = cur;
		r.switched = sw;
		expected_results.push_back(r);
	endtask

	function automatic cmd_beat_t mk(input logic [2:0] k, input logic [3:0] t);
		cmd_beat_t c;
		c.kind = k;
		c.tgt = t;
		return c;
	endfunction

	// Driver.
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			schedule_cmd(mk(kind, target_thread));
			accepted <= accepted + 1;
		end
		if (!(in_valid && !in_ready)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_cmds.size() > 0 && !hold_off && arst_n) begin
				in_valid <= 1'b1;
				kind <= pending_cmds[0].kind;
				target_thread <= pending_cmds[0].tgt;
				void'(pending_cmds.pop_front());
				if (burst_left > 0) burst_left <= burst_left - 1;
				else begin
					burst_left <= $urandom_range(0, 12);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		out_ready <= (cycles % 600 < 150) ? 1'b1 : ($urandom_range(0, 3) != 0);
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10) $display("unexpected result beat status=%0d", status);
			end else if (expected_results[0] !== {status, new_thread, running_thread, switched})
			begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("mismatch exp st=%0d nt=%0d rt=%0d sw=%0d got %0d %0d %0d %0d",
						expected_results[0].status, expected_results[0].new_thread,
						expected_results[0].running_thread, expected_results[0].switched,
						status, new_thread, running_thread, switched);
				void'(expected_results.pop_front());
			end else begin
				void'(expected_results.pop_front());
			end
		end
	end

	// Draws random commands with weighted kinds (create, yield, exit, join,
	// resume, register, and bad kinds 6 and 7) and random targets.
	task automatic add_random(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 18) pending_cmds.push_back(mk(tls_pkg::K_CREATE, 4'($urandom)));
			else if (r < 40) pending_cmds.push_back(mk(tls_pkg::K_YIELD, 4'($urandom)));
			else if (r < 55) pending_cmds.push_back(mk(tls_pkg::K_EXIT, 4'($urandom)));
			else if (r < 75) pending_cmds.push_back(mk(tls_pkg::K_JOIN, 4'($urandom)));
			else if (r < 85) pending_cmds.push_back(mk(tls_pkg::K_RESUME, 4'($urandom)));
			else if (r < 95) pending_cmds.push_back(mk(tls_pkg::K_REGISTER, 4'($urandom)));
			else pending_cmds.push_back(mk(3'($urandom_range(6, 7)), 4'($urandom)));
		end
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (cycles > 400000) begin
			$display("[thread_lifecycle_scheduler] ERROR");
			$finish;
		end
	end

	initial begin
		sched_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// Directed: bad kinds, invalid targets, create to exhaustion, a join,
		// an exit with joiners, then a yield.
		pending_cmds.push_back(mk(3'd6, 4'd0));
		pending_cmds.push_back(mk(3'd7, 4'd15));
		pending_cmds.push_back(mk(tls_pkg::K_JOIN, 4'd0));
		pending_cmds.push_back(mk(tls_pkg::K_JOIN, 4'd15));
		pending_cmds.push_back(mk(tls_pkg::K_REGISTER, 4'd9));
		pending_cmds.push_back(mk(tls_pkg::K_RESUME, 4'd9));
		for (int i = 0; i < 16; i++) pending_cmds.push_back(mk(tls_pkg::K_CREATE, 4'd0));
		pending_cmds.push_back(mk(tls_pkg::K_JOIN, 4'd1));
		pending_cmds.push_back(mk(tls_pkg::K_EXIT, 4'd0));
		pending_cmds.push_back(mk(tls_pkg::K_YIELD, 4'd0));
		wait_drained();
		for (int p = 0; p < 12; p++) begin
			// Reset only once, so later phases reach halt and stay there;
			// the leading phases still give many live results.
			add_random(150);
			if (p == 3) begin
				wait_drained();
				hold_off = 1'b1;
				repeat (5) @(posedge clk);
				hold_off = 1'b0;
			end
		end
		wait_drained();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("[thread_lifecycle_scheduler] OK");
		else
			$display("[thread_lifecycle_scheduler] ERROR");
		$finish;
	end
endmodule
